@@ hw/rtl/stf_pkg.sv @@
// shared types, constants and helpers of the sensor telemetry frame formatter
// no dependencies; imported by every module of the block

package stf_pkg;

   // default frame layout
   localparam int SENSOR_RECORDS_DEF = 8;
   localparam int GAS_RECORDS_DEF    = 2;

   // value lanes and widths
   localparam int VAL_W       = 14;
   localparam int DIG_W       = 16;
   localparam int LANES       = 4;
   localparam int CNT_W       = $clog2(VAL_W + 1);
   localparam int POS_W       = 5;
   localparam int QUEUE_DEPTH = 2;

   // lane assignment; gas records reuse the first lane
   localparam int LANE_TEMP  = 0;
   localparam int LANE_GAS   = 0;
   localparam int LANE_HUM   = 1;
   localparam int LANE_PRESS = 2;
   localparam int LANE_LIGHT = 3;

   // saturation limit for four printed digits
   localparam logic [VAL_W-1:0] SAT_MAX = 14'd9999;

   // pressure in hPa: (raw + 65536) * recip >> shift equals division by 100
   localparam int             PRESS_W     = 17;
   localparam int             RECIP_W     = 18;
   localparam int             PROD_W      = PRESS_W + RECIP_W;
   localparam int             PRESS_SHIFT = 24;
   localparam int             HPA_W       = 11;
   localparam logic [RECIP_W-1:0] PRESS_RECIP = 18'd167773;

   // frame bytes
   localparam logic [7:0] HDR_BYTE0  = 8'h01;
   localparam logic [7:0] HDR_BYTE1  = 8'h02;
   localparam logic [7:0] HDR_BYTE2  = 8'h01;
   localparam logic [7:0] GAS_PAD    = 8'h00;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [3:0] ASCII_HIGH = 4'h3;

   // last byte position of each section
   localparam logic [POS_W-1:0] HEAD_LAST_POS   = 5'd2;
   localparam logic [POS_W-1:0] SENSOR_LAST_POS = 5'd17;
   localparam logic [POS_W-1:0] GAS_LAST_POS    = 5'd5;
   localparam logic [POS_W-1:0] CRC_LAST_POS    = 5'd1;

   // crc-16/modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // record classification made by the front end
   typedef struct packed {
      logic       hdr;
      logic       last;
      logic       gas;
      logic [7:0] addr;
      logic [7:0] err;
   } stf_meta_type;

   // record handed from front to back: classification and decimal digits
   typedef struct packed {
      stf_meta_type                  meta;
      logic [LANES-1:0][DIG_W-1:0]   dig;
   } stf_rec_type;

   // byte sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_BODY,
      ST_CRC
   } stf_state_type;

endpackage

@@ hw/rtl/stf_front.sv @@
// front end: accepts node records, numbers and classifies them, converts values to decimal
// depends on stf_pkg

module stf_front #(
   parameter int SENSOR_RECORDS = stf_pkg::SENSOR_RECORDS_DEF,
   parameter int GAS_RECORDS    = stf_pkg::GAS_RECORDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [79:0]         req_tdata,
   output logic                push,
   output stf_pkg::stf_rec_type push_rec,
   input  logic                q_full
);
   import stf_pkg::*;

   localparam int TOTAL = SENSOR_RECORDS + GAS_RECORDS;
   localparam int IDX_W = $clog2(TOTAL);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TOTAL - 1);
   localparam logic [IDX_W-1:0] IDX_GAS  = IDX_W'(SENSOR_RECORDS);

   // one double-dabble step: adjust digits, then shift in the next binary bit
   function automatic logic [DIG_W+VAL_W-1:0] dd_step(input logic [DIG_W-1:0] bcd,
                                                      input logic [VAL_W-1:0] bin);
      logic [DIG_W-1:0] adj;
      for (int d = 0; d < DIG_W / 4; d++) begin
         adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? (bcd[d*4 +: 4] + 4'd3) : bcd[d*4 +: 4];
      end
      return {adj[DIG_W-2:0], bin, 1'b0};
   endfunction

   function automatic logic [VAL_W-1:0] sat4(input logic [VAL_W-1:0] v);
      return (v > SAT_MAX) ? SAT_MAX : v;
   endfunction

   // input fields
   logic [7:0]         f_err;
   logic [VAL_W-1:0]   f_temp;
   logic [VAL_W-1:0]   f_hum;
   logic [15:0]        f_press;
   logic [VAL_W-1:0]   f_light;
   logic [VAL_W-1:0]   f_gas;

   assign f_err   = req_tdata[7:0];
   assign f_temp  = req_tdata[21:8];
   assign f_hum   = req_tdata[35:22];
   assign f_press = req_tdata[51:36];
   assign f_light = req_tdata[65:52];
   assign f_gas   = req_tdata[79:66];

   // record counter
   logic [IDX_W-1:0] idx_ff, idx_in;
   // input stage
   logic                          a_valid_ff, a_valid_in;
   stf_meta_type                  a_meta_ff, a_meta_in;
   logic [LANES-1:0][VAL_W-1:0]   a_bin_ff, a_bin_in;
   // converter
   logic                          cv_busy_ff, cv_busy_in;
   logic [CNT_W-1:0]              cv_cnt_ff, cv_cnt_in;
   stf_meta_type                  cv_meta_ff, cv_meta_in;
   logic [LANES-1:0][VAL_W-1:0]   cv_bin_ff, cv_bin_in;
   logic [LANES-1:0][DIG_W-1:0]   cv_bcd_ff, cv_bcd_in;

   logic                accept;
   logic                load;
   logic                rec_last;
   logic [PRESS_W-1:0]  press;
   logic [PROD_W-1:0]   prod;

   // handshake and stage movement
   assign push       = cv_busy_ff && (cv_cnt_ff == '0) && !q_full;
   assign load       = a_valid_ff && (!cv_busy_ff || push);
   assign req_tready = !a_valid_ff || load;
   assign accept     = req_tvalid && req_tready;
   assign rec_last   = (idx_ff == IDX_LAST);

   // pressure: raw plus 65536 when present, scaled to hPa by reciprocal
   assign press = (f_press != '0) ? {1'b1, f_press} : '0;
   assign prod  = PROD_W'(press) * PROD_W'(PRESS_RECIP);

   // record numbering and input stage capture
   always_comb begin
      idx_in     = idx_ff;
      a_valid_in = a_valid_ff;
      a_meta_in  = a_meta_ff;
      a_bin_in   = a_bin_ff;
      if (load) begin
         a_valid_in = 1'b0;
      end
      if (accept) begin
         idx_in          = rec_last ? '0 : idx_ff + 1'b1;
         a_valid_in      = 1'b1;
         a_meta_in.hdr   = (idx_ff == '0);
         a_meta_in.last  = rec_last;
         a_meta_in.gas   = (idx_ff >= IDX_GAS);
         a_meta_in.addr  = 8'(idx_ff) + 8'd1;
         a_meta_in.err   = f_err;
         a_bin_in[LANE_TEMP]  = (idx_ff >= IDX_GAS) ? sat4(f_gas) : sat4(f_temp);
         a_bin_in[LANE_HUM]   = sat4(f_hum);
         a_bin_in[LANE_PRESS] = VAL_W'(prod[PRESS_SHIFT +: HPA_W]);
         a_bin_in[LANE_LIGHT] = sat4(f_light);
      end
   end

   // binary to decimal converter, one bit per cycle on all lanes
   always_comb begin
      cv_busy_in = cv_busy_ff;
      cv_cnt_in  = cv_cnt_ff;
      cv_meta_in = cv_meta_ff;
      cv_bin_in  = cv_bin_ff;
      cv_bcd_in  = cv_bcd_ff;
      if (load) begin
         cv_busy_in = 1'b1;
         cv_cnt_in  = CNT_W'(VAL_W);
         cv_meta_in = a_meta_ff;
         cv_bin_in  = a_bin_ff;
         cv_bcd_in  = '0;
      end else if (push) begin
         cv_busy_in = 1'b0;
      end else if (cv_busy_ff && (cv_cnt_ff != '0)) begin
         cv_cnt_in = cv_cnt_ff - 1'b1;
         for (int l = 0; l < LANES; l++) begin
            {cv_bcd_in[l], cv_bin_in[l]} = dd_step(cv_bcd_ff[l], cv_bin_ff[l]);
         end
      end
   end

   assign push_rec.meta = cv_meta_ff;
   assign push_rec.dig  = cv_bcd_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         a_valid_ff <= 1'b0;
         cv_busy_ff <= 1'b0;
         cv_cnt_ff  <= '0;
      end else begin
         idx_ff     <= idx_in;
         a_valid_ff <= a_valid_in;
         cv_busy_ff <= cv_busy_in;
         cv_cnt_ff  <= cv_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_meta_ff  <= a_meta_in;
      a_bin_ff   <= a_bin_in;
      cv_meta_ff <= cv_meta_in;
      cv_bin_ff  <= cv_bin_in;
      cv_bcd_ff  <= cv_bcd_in;
   end

   // record counter stays inside the frame
   assert property (@(posedge clock) disable iff (reset) idx_ff <= IDX_LAST)
      else $error("record counter beyond frame length");

   // a new record only enters the converter once the previous one has left
   assert property (@(posedge clock) disable iff (reset)
      load && cv_busy_ff |-> push && (cv_cnt_ff == '0))
      else $error("converter overwritten before hand-off");

endmodule

@@ hw/rtl/stf_fifo.sv @@
// short record queue between front end and byte sequencer
// depends on stf_pkg

module stf_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stf_pkg::stf_rec_type push_rec,
   output logic                 full,
   input  logic                 pop,
   output stf_pkg::stf_rec_type pop_rec,
   output logic                 empty
);
   import stf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QUEUE_DEPTH);

   stf_rec_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]         cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign pop_rec = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full record queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty record queue");

endmodule

@@ hw/rtl/stf_back.sv @@
// byte sequencer: emits header, record body and checksum bytes with a running crc
// depends on stf_pkg

module stf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rec_valid,
   input  stf_pkg::stf_rec_type rec,
   output logic                 rec_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte [7:0]
   output logic                 rsp_tlast,
   output logic                 rsp_tuser    // frame_end [0]
);
   import stf_pkg::*;

   // crc-16/modbus over one byte, lsb first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] asc(input logic [3:0] d);
      return {ASCII_HIGH, d};
   endfunction

   stf_state_type       st_ff, st_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   stf_rec_type         cur_ff, cur_in;
   logic [15:0]         crc_ff, crc_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                out_frame_ff, out_frame_in;

   logic        out_free;
   logic        adv;
   logic        sec_end;
   logic        rec_end;
   logic        start;
   logic [7:0]  byte_val;
   logic        byte_item_end;
   logic        byte_frame_end;
   logic [LANES-1:0][DIG_W-1:0] dg;

   assign dg       = cur_ff.dig;
   assign out_free = !out_valid_ff || rsp_tready;
   assign adv      = (st_ff != ST_IDLE) && out_free;
   assign rec_end  = sec_end && (((st_ff == ST_BODY) && !cur_ff.meta.last) || (st_ff == ST_CRC));
   assign start    = rec_valid && ((st_ff == ST_IDLE) || (adv && rec_end));
   assign rec_pop  = start;

   // section end detection
   always_comb begin
      unique case (st_ff)
         ST_HEAD: sec_end = (pos_ff == HEAD_LAST_POS);
         ST_BODY: sec_end = cur_ff.meta.gas ? (pos_ff == GAS_LAST_POS)
                                            : (pos_ff == SENSOR_LAST_POS);
         ST_CRC:  sec_end = (pos_ff == CRC_LAST_POS);
         default: sec_end = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) st_in = rec.meta.hdr ? ST_HEAD : ST_BODY;
         end
         ST_HEAD: begin
            if (adv && sec_end) st_in = ST_BODY;
         end
         ST_BODY: begin
            if (adv && sec_end) begin
               if (cur_ff.meta.last) st_in = ST_CRC;
               else if (start)       st_in = rec.meta.hdr ? ST_HEAD : ST_BODY;
               else                  st_in = ST_IDLE;
            end
         end
         ST_CRC: begin
            if (adv && sec_end) begin
               if (start) st_in = rec.meta.hdr ? ST_HEAD : ST_BODY;
               else       st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // byte selection for the current state and position
   always_comb begin
      byte_val       = GAS_PAD;
      byte_item_end  = rec_end;
      byte_frame_end = (st_ff == ST_CRC) && sec_end;
      unique case (st_ff)
         ST_HEAD: begin
            unique case (pos_ff)
               5'd0:    byte_val = HDR_BYTE0;
               5'd1:    byte_val = HDR_BYTE1;
               default: byte_val = HDR_BYTE2;
            endcase
         end
         ST_BODY: begin
            if (cur_ff.meta.gas) begin
               unique case (pos_ff)
                  5'd0:    byte_val = cur_ff.meta.addr;
                  5'd1:    byte_val = GAS_PAD;
                  5'd2:    byte_val = asc(dg[LANE_GAS][15:12]);
                  5'd3:    byte_val = asc(dg[LANE_GAS][11:8]);
                  5'd4:    byte_val = asc(dg[LANE_GAS][7:4]);
                  default: byte_val = asc(dg[LANE_GAS][3:0]);
               endcase
            end else begin
               unique case (pos_ff)
                  5'd0:    byte_val = cur_ff.meta.addr;
                  5'd1:    byte_val = cur_ff.meta.err;
                  // temperature: tens, units, dot, tenths
                  5'd2:    byte_val = asc(dg[LANE_TEMP][15:12]);
                  5'd3:    byte_val = asc(dg[LANE_TEMP][11:8]);
                  5'd4:    byte_val = DOT_CHAR;
                  5'd5:    byte_val = asc(dg[LANE_TEMP][7:4]);
                  // humidity in the same form
                  5'd6:    byte_val = asc(dg[LANE_HUM][15:12]);
                  5'd7:    byte_val = asc(dg[LANE_HUM][11:8]);
                  5'd8:    byte_val = DOT_CHAR;
                  5'd9:    byte_val = asc(dg[LANE_HUM][7:4]);
                  // pressure in hPa, four digits
                  5'd10:   byte_val = asc(dg[LANE_PRESS][15:12]);
                  5'd11:   byte_val = asc(dg[LANE_PRESS][11:8]);
                  5'd12:   byte_val = asc(dg[LANE_PRESS][7:4]);
                  5'd13:   byte_val = asc(dg[LANE_PRESS][3:0]);
                  // illuminance, four digits
                  5'd14:   byte_val = asc(dg[LANE_LIGHT][15:12]);
                  5'd15:   byte_val = asc(dg[LANE_LIGHT][11:8]);
                  5'd16:   byte_val = asc(dg[LANE_LIGHT][7:4]);
                  default: byte_val = asc(dg[LANE_LIGHT][3:0]);
               endcase
            end
         end
         ST_CRC: begin
            byte_val = (pos_ff == '0) ? crc_ff[7:0] : crc_ff[15:8];
         end
         default: byte_val = GAS_PAD;
      endcase
   end

   // position, current record, crc and output register
   always_comb begin
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_frame_in = out_frame_ff;
      if (adv) begin
         pos_in = sec_end ? '0 : pos_ff + 1'b1;
         if (st_ff == ST_CRC) begin
            if (sec_end) crc_in = CRC_INIT;
         end else begin
            crc_in = crc_step(crc_ff, byte_val);
         end
      end
      if (start) begin
         cur_in = rec;
         pos_in = '0;
      end
      if (adv) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_val;
         out_last_in  = byte_item_end;
         out_frame_in = byte_frame_end;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_frame_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_frame_ff <= out_frame_in;
   end

   // every frame starts from the initial crc
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_HEAD) && (pos_ff == '0) |-> crc_ff == CRC_INIT)
      else $error("crc not restarted at frame header");

   // the frame's final byte also closes its record
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without record end");

endmodule

@@ hw/rtl/sensor_telemetry_frame_formatter_unit.sv @@
// Sensor telemetry frame formatter.
// Input channel (req_): one node record per transaction; a frame is
// SENSOR_RECORDS sensor records followed by GAS_RECORDS gas records.
// Output channel (rsp_): one frame byte per transaction. tlast marks the last
// byte caused by a record, tuser marks the final checksum byte of the frame.
// The first record of a frame is preceded by 01 02 01; the last one is
// followed by the CRC-16/MODBUS of the frame, low byte first.
// Before its first byte appears, a record passes the capture register,
// 14 binary-to-decimal steps and the hand-off to the record queue.
// The byte sequencer emits one byte per cycle unless the receiver stalls it;
// a sensor record is 18 bytes (21 with header, 20 with checksum). The decimal
// converter holds one record at a time; it paces gas records (6 bytes each).
// A two-entry record queue lets the front end keep accepting while the
// receiver stalls; when it fills, req_tready drops until bytes drain.
// Reset (synchronous, active high) empties the pipeline, restarts the record
// count at the first sensor record and sets the checksum to FFFF.
// Depends on stf_pkg, stf_front, stf_fifo and stf_back.

module sensor_telemetry_frame_formatter_unit #(
   parameter int SENSOR_RECORDS = stf_pkg::SENSOR_RECORDS_DEF,
   parameter int GAS_RECORDS    = stf_pkg::GAS_RECORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // error_code [7:0], temperature [21:8], humidity [35:22],
   // pressure_raw [51:36], illuminance [65:52], gas_level [79:66]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast,   // item_end
   output logic        rsp_tuser    // frame_end [0]
);
   import stf_pkg::*;

   logic        push;
   logic        q_full;
   logic        q_empty;
   logic        pop;
   stf_rec_type push_rec;
   stf_rec_type head_rec;

   // front end: capture, classify, convert to decimal
   stf_front #(
      .SENSOR_RECORDS (SENSOR_RECORDS),
      .GAS_RECORDS    (GAS_RECORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_rec   (push_rec),
      .q_full     (q_full)
   );

   // record queue
   stf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (pop),
      .pop_rec  (head_rec),
      .empty    (q_empty)
   );

   // byte sequencer with checksum
   stf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (!q_empty),
      .rec        (head_rec),
      .rec_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/sv/sensor_telemetry_frame_formatter_unit_tb.sv @@
// testbench for the sensor telemetry frame formatter: random and directed node records
// are streamed in and every frame byte is checked against an in-bench frame predictor
// depends on stf_pkg and sensor_telemetry_frame_formatter_unit
`timescale 1ns / 1ps

module sensor_telemetry_frame_formatter_unit_tb;

   // frame layout follows the block defaults
   localparam int SENSOR_COUNT = stf_pkg::SENSOR_RECORDS_DEF;
   localparam int GAS_COUNT    = stf_pkg::GAS_RECORDS_DEF;
   localparam int RECORD_COUNT = SENSOR_COUNT + GAS_COUNT;

   // frame bytes and checksum
   localparam logic [7:0]  HEADER_B0    = 8'h01;
   localparam logic [7:0]  HEADER_B1    = 8'h02;
   localparam logic [7:0]  HEADER_B2    = 8'h01;
   localparam logic [7:0]  GAS_FILL     = 8'h00;
   localparam logic [7:0]  ASCII_ZERO   = 8'h30;
   localparam logic [7:0]  ASCII_DOT    = 8'h2E;
   localparam logic [15:0] CRC_SEED     = 16'hFFFF;
   localparam logic [15:0] CRC_REFL     = 16'hA001;
   localparam int          PRINT_MAX    = 9999;
   localparam int          PRESS_OFFSET = 65536;

   // run control
   localparam int RANDOM_RECORDS = 150;
   localparam int LONG_HOLD      = 250;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       item_end;
      logic       frame_end;
   } frame_byte_type;

   typedef struct packed {
      logic [79:0] tdata;
      logic [2:0]  gap;
   } node_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   node_record_type records_to_send[$];
   frame_byte_type  frame_bytes_due[$];
   frame_byte_type  record_bytes[$];

   // predictor state
   int          frame_pos = 0;
   logic [15:0] frame_crc = CRC_SEED;

   int          send_wait;
   int          records_accepted;
   int          bytes_received;
   int          recv_wait;
   int          hold_left;
   int          holds_done;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   sensor_telemetry_frame_formatter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- frame predictor

   function automatic logic [15:0] modbus_crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_REFL) : (r >> 1);
      end
      return r;
   endfunction

   function automatic int clamp_print(logic [13:0] v);
      return (int'(v) > PRINT_MAX) ? PRINT_MAX : int'(v);
   endfunction

   function automatic logic [7:0] digit_char(int d);
      return ASCII_ZERO + 8'(d);
   endfunction

   task automatic add_record_byte(input logic [7:0] b);
      frame_byte_type fb;
      fb = '{data: b, item_end: 1'b0, frame_end: 1'b0};
      record_bytes.push_back(fb);
      frame_crc = modbus_crc_step(frame_crc, b);
   endtask

   // tens, units, dot, tenths
   task automatic add_fixed_point(input int v);
      add_record_byte(digit_char(v / 1000));
      add_record_byte(digit_char((v % 1000) / 100));
      add_record_byte(ASCII_DOT);
      add_record_byte(digit_char((v % 100) / 10));
   endtask

   task automatic add_four_digits(input int v);
      add_record_byte(digit_char(v / 1000));
      add_record_byte(digit_char((v % 1000) / 100));
      add_record_byte(digit_char((v % 100) / 10));
      add_record_byte(digit_char(v % 10));
   endtask

   // bytes caused by one accepted record, appended to the expected byte stream
   task automatic predict_record_bytes(input logic [79:0] rec);
      logic [7:0]     err;
      logic [13:0]    temp;
      logic [13:0]    hum;
      logic [15:0]    press_raw;
      logic [13:0]    light;
      logic [13:0]    gas;
      int             press_pa;
      frame_byte_type fb;
      err       = rec[7:0];
      temp      = rec[21:8];
      hum       = rec[35:22];
      press_raw = rec[51:36];
      light     = rec[65:52];
      gas       = rec[79:66];
      record_bytes.delete();

      // header opens a frame
      if (frame_pos == 0) begin
         frame_crc = CRC_SEED;
         add_record_byte(HEADER_B0);
         add_record_byte(HEADER_B1);
         add_record_byte(HEADER_B2);
      end

      if (frame_pos < SENSOR_COUNT) begin
         press_pa = (press_raw != 0) ? int'(press_raw) + PRESS_OFFSET : 0;
         add_record_byte(8'(frame_pos + 1));
         add_record_byte(err);
         add_fixed_point(clamp_print(temp));
         add_fixed_point(clamp_print(hum));
         add_four_digits(press_pa / 100);
         add_four_digits(clamp_print(light));
      end else begin
         add_record_byte(8'(frame_pos + 1));
         add_record_byte(GAS_FILL);
         add_four_digits(clamp_print(gas));
      end
      frame_pos++;

      // checksum closes a frame, low byte first, not itself covered
      if (frame_pos >= RECORD_COUNT) begin
         fb = '{data: frame_crc[7:0], item_end: 1'b0, frame_end: 1'b0};
         record_bytes.push_back(fb);
         fb = '{data: frame_crc[15:8], item_end: 1'b0, frame_end: 1'b1};
         record_bytes.push_back(fb);
         frame_pos = 0;
         frame_crc = CRC_SEED;
      end

      foreach (record_bytes[i]) begin
         fb = record_bytes[i];
         fb.item_end = (i == record_bytes.size() - 1);
         frame_bytes_due.push_back(fb);
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [79:0] pack_record(logic [7:0] err, logic [13:0] temp,
                                               logic [13:0] hum, logic [15:0] press_raw,
                                               logic [13:0] light, logic [13:0] gas);
      return {gas, light, press_raw, hum, temp, err};
   endfunction

   // full field range, with extra weight around the saturation point
   function automatic logic [13:0] rand_reading();
      if ($urandom_range(0, 3) == 0)
         return 14'($urandom_range(9990, 10010));
      return 14'($urandom_range(0, 16383));
   endfunction

   function automatic logic [15:0] rand_pressure();
      if ($urandom_range(0, 7) == 0)
         return 16'h0000;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_record(input logic [79:0] rec, input int gap);
      node_record_type nr;
      nr.tdata = rec;
      nr.gap   = 3'(gap);
      records_to_send.push_back(nr);
   endtask

   // ---------------------------------------------------------------- input driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid       <= 1'b0;
         send_wait        <= 0;
         records_accepted <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_record_bytes(req_tdata);
            records_accepted <= records_accepted + 1;
         end
         if (req_tvalid && !req_tready) begin
            // transaction still pending, hold it
         end else if (send_wait != 0) begin
            req_tvalid <= 1'b0;
            send_wait  <= send_wait - 1;
         end else if (records_to_send.size() != 0) begin
            node_record_type nr;
            nr = records_to_send.pop_front();
            req_tdata  <= nr.tdata;
            req_tvalid <= 1'b1;
            send_wait  <= int'(nr.gap);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- long receiver hold

   // two long stalls so the record queue fills and input backpressure shows
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && records_accepted >= 30 + 80 * holds_done) begin
         hold_left  <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   // ---------------------------------------------------------------- output monitor

   always @(posedge clock) begin : byte_receiver
      int             next_wait;
      frame_byte_type want;
      if (reset) begin
         rsp_tready     <= 1'b0;
         recv_wait      <= 0;
         bytes_received <= 0;
      end else begin
         next_wait = recv_wait;
         if (rsp_tvalid && rsp_tready) begin
            bytes_received <= bytes_received + 1;
            if (frame_bytes_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected byte %02h last %0b frame_end %0b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  mismatch_count++;
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.data, rsp_tdata);
               end
               if (rsp_tlast !== want.item_end) begin
                  mismatch_count++;
                  $display("%0t: item_end expected %0b actual %0b",
                           $time, want.item_end, rsp_tlast);
               end
               if (rsp_tuser !== want.frame_end) begin
                  mismatch_count++;
                  $display("%0t: frame_end expected %0b actual %0b",
                           $time, want.frame_end, rsp_tuser);
               end
            end
            // every third stretch of 100 bytes runs without stalls
            next_wait = ((bytes_received / 100) % 3 == 2) ? 0 : $urandom_range(0, 4);
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            recv_wait  <= next_wait;
         end else if (next_wait > 0) begin
            rsp_tready <= 1'b0;
            recv_wait  <= next_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_wait  <= 0;
         end
      end
   end

   // ---------------------------------------------------------------- timeout

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // directed frame: field extremes, saturation, pressure absent and edges
      queue_record(pack_record(8'h00, 14'd0, 14'd0, 16'd0, 14'd0, 14'd0), 0);
      queue_record(pack_record(8'hFF, 14'd9999, 14'd9999, 16'hFFFF, 14'd9999, 14'h3FFF), 1);
      queue_record(pack_record(8'h5A, 14'd10000, 14'h3FFF, 16'd1, 14'd10000, 14'd0), 0);
      queue_record(pack_record(8'hA5, 14'h3FFF, 14'd10000, 16'd34464, 14'h3FFF, 14'd77), 2);
      queue_record(pack_record(8'h01, 14'd1234, 14'd5678, 16'd99, 14'd1, 14'd5), 0);
      queue_record(pack_record(8'h80, 14'd9, 14'd10, 16'hFFFE, 14'd999, 14'h2AAA), 0);
      queue_record(pack_record(8'h7F, 14'd9998, 14'd1, 16'h8000, 14'd1000, 14'h1555), 3);
      queue_record(pack_record(8'h33, 14'h2AAA, 14'h1555, 16'h5555, 14'h2AAA, 14'd9999), 0);
      // gas records with the sensor fields at their extremes, which must be ignored
      queue_record(pack_record(8'hFF, 14'h3FFF, 14'h3FFF, 16'hFFFF, 14'h3FFF, 14'd0), 0);
      queue_record(pack_record(8'h00, 14'd0, 14'd0, 16'd0, 14'd0, 14'h3FFF), 4);
      // second frame, back to back, to see the checksum restart
      queue_record(pack_record(8'hC3, 14'd5000, 14'd2500, 16'h0001, 14'd10001, 14'd0), 0);
      queue_record(pack_record(8'h3C, 14'd10001, 14'd9999, 16'h0000, 14'd0, 14'd0), 0);
      for (int i = 0; i < 6; i++) begin
         queue_record(pack_record(8'($urandom_range(0, 255)), rand_reading(), rand_reading(),
                                  rand_pressure(), rand_reading(), rand_reading()), 0);
      end
      queue_record(pack_record(8'h00, 14'd0, 14'd0, 16'd0, 14'd0, 14'd9999), 0);
      queue_record(pack_record(8'h00, 14'd0, 14'd0, 16'd0, 14'd0, 14'd10000), 0);

      // random records, alternating stretches with and without sender gaps
      for (int i = 0; i < RANDOM_RECORDS; i++) begin
         queue_record(pack_record(8'($urandom_range(0, 255)), rand_reading(), rand_reading(),
                                  rand_pressure(), rand_reading(), rand_reading()),
                      ((i / 25) % 2 == 1) ? 0 : $urandom_range(0, 4));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for all transactions to be taken and all bytes to arrive
      while (records_to_send.size() != 0 || req_tvalid) @(negedge clock);
      while (frame_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && frame_bytes_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/stf_pkg.sv
hw/rtl/stf_front.sv
hw/rtl/stf_fifo.sv
hw/rtl/stf_back.sv
hw/rtl/sensor_telemetry_frame_formatter_unit.sv
tb/sv/sensor_telemetry_frame_formatter_unit_tb.sv
